// File: rtl/core/sheu_pkg.sv
// ----------------------------------------------------------------------------
// sheu_pkg: shared types and constants of the stereo harmonic exciter
// Fixed-point formats, config record, lane sequencer steps and tanh table.
// ----------------------------------------------------------------------------
package sheu_pkg;

   localparam int SAMPLE_BITS      = 24;
   localparam int FRAC             = SAMPLE_BITS - 1;
   localparam int COEF_FRAC_BITS   = 22;
   localparam int TANH_TABLE_DEPTH = 1024;
   localparam int TANH_LOG2        = $clog2(TANH_TABLE_DEPTH);
   localparam int TANH_IDX_W       = TANH_LOG2 + 1;
   localparam int COEF_W           = 24;
   localparam int DRIVE_W          = 16;
   localparam int GAIN_W           = 24;
   localparam int MUL_A_W          = SAMPLE_BITS + 3;
   localparam int MUL_B_W          = 25;
   localparam int ACC_W            = MUL_A_W + MUL_B_W;
   localparam int CSR_IDX_W        = 8;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_PRE_B0  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRE_A1  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PRE_A2  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_POST_B0 = 8'd3;
   localparam logic [CSR_IDX_W-1:0] REG_POST_A1 = 8'd4;
   localparam logic [CSR_IDX_W-1:0] REG_POST_A2 = 8'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE   = 8'd6;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN    = 8'd7;

   typedef struct packed {
      logic signed [COEF_W-1:0]  pre_b0;
      logic signed [COEF_W-1:0]  pre_a1;
      logic signed [COEF_W-1:0]  pre_a2;
      logic signed [COEF_W-1:0]  post_b0;
      logic signed [COEF_W-1:0]  post_a1;
      logic signed [COEF_W-1:0]  post_a2;
      logic [DRIVE_W-1:0]        drive;
      logic [GAIN_W-1:0]         harmonic_gain;
   } coef_type;

   typedef struct packed {
      logic start;
   } lane_ctrl_type;

   typedef struct packed {
      logic done;
   } lane_stat_type;

   typedef enum logic [3:0] {
      ST_PRE_B0, ST_PRE_A1, ST_PRE_A2, ST_PRE_ACC, ST_PRE_OUT,
      ST_DRIVE, ST_INDEX, ST_LOOKUP,
      ST_POST_B0, ST_POST_A1, ST_POST_A2, ST_POST_ACC, ST_POST_OUT,
      ST_GAIN, ST_MIX, ST_IDLE
   } lane_step_type;

   typedef logic [FRAC-1:0] tanh_rom_type [0:TANH_TABLE_DEPTH];

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< FRAC) - 64'sd1;
      lo = -(64'sd1 <<< FRAC);
      if (v > hi) return hi[SAMPLE_BITS-1:0];
      else if (v < lo) return lo[SAMPLE_BITS-1:0];
      else return v[SAMPLE_BITS-1:0];
   endfunction

   // shift-subtract quotient of a numerator below 2^64, used while building the table
   function automatic logic [127:0] div_u64(logic [127:0] num, logic [127:0] den);
      logic [127:0] quo;
      logic [127:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = (rem << 1) | ((num >> b) & 128'd1);
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | (128'd1 << b);
         end
      end
      return quo;
   endfunction

   // tanh(4k/DEPTH) in Q.FRAC through e^-2x = (e^-z)^16, z = k/(2*DEPTH)
   function automatic logic [FRAC-1:0] tanh_entry(int unsigned k);
      logic [127:0] one;
      logic [127:0] z;
      logic [127:0] term;
      logic [127:0] pos;
      logic [127:0] neg;
      logic [127:0] e;
      logic [127:0] r;
      one  = 128'd1 << 32;
      z    = (128'(k) << 32) >> (TANH_LOG2 + 1);
      term = one;
      pos  = one;
      neg  = '0;
      for (int n = 1; n <= 12; n++) begin
         term = div_u64((term * z) >> 32, 128'(n));
         if (n % 2 == 1) neg = neg + term;
         else pos = pos + term;
      end
      e = (pos - neg) & 128'hFFFF_FFFF_FFFF_FFFF;
      if (e > 128'hFFFF_FFFF) e = 128'hFFFF_FFFF;
      for (int i = 0; i < 4; i++) e = (e * e) >> 32;
      r = div_u64(((one - e) << 32) & 128'hFFFF_FFFF_FFFF_FFFF, one + e);
      r = (r + (128'd1 << (31 - FRAC))) >> (32 - FRAC);
      if (r > (128'd1 << FRAC) - 128'd1) r = (128'd1 << FRAC) - 128'd1;
      return r[FRAC-1:0];
   endfunction

   function automatic tanh_rom_type build_tanh_rom();
      tanh_rom_type rom;
      for (int k = 0; k <= TANH_TABLE_DEPTH; k++) rom[k] = tanh_entry(k);
      return rom;
   endfunction

endpackage

// File: rtl/core/stereo_harmonic_exciter_unit.sv
// ----------------------------------------------------------------------------
// stereo_harmonic_exciter_unit: stereo harmonic exciter, top level
// Two channel lanes in parallel and an output register that merges them.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one stereo frame per request, left in tdata[23:0], right in [47:24].
//   rsp_*  : one stereo frame per request, same packing, dry plus harmonics.
//   csr_*  : register writes (index, data); always ready, write only while idle.
// Each lane runs a 15-step sequence around one shared 27x25 multiplier:
// highpass (three products), drive, table index, tanh lookup, highpass,
// harmonic gain and mix. The next request is taken the cycle after the output
// register has been loaded, so a frame is not accepted while the lanes still
// hold the previous one; the frame rate is set by the multiplier sequence of
// a lane plus the merge into the output register.
// Reset clears the filter histories, restores the registers to their reset
// values (drive 1.0, everything else 0) and empties the output register.
// When the receiver stalls, the result waits in the output register; a new
// request is accepted and processed, then holds in the lanes until the
// output register frees.
// ----------------------------------------------------------------------------
module stereo_harmonic_exciter_unit
   import sheu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,   // left_in[23:0], right_in[47:24]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,   // left_out[23:0], right_out[47:24]
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [23:0]          csr_data
);

   coef_type coef_ff;
   logic     busy_ff;
   logic     rsp_valid_ff;
   logic [47:0] rsp_data_ff;
   lane_ctrl_type ctrl;
   lane_stat_type stat_l, stat_r;
   logic signed [SAMPLE_BITS-1:0] out_l, out_r;
   logic req_fire, merge;

   assign csr_ready  = 1'b1;
   assign req_tready = !busy_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign ctrl.start = req_fire;
   // merge both lanes once they finish and the output register is free
   assign merge = busy_ff && stat_l.done && stat_r.done && (!rsp_valid_ff || rsp_tready);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '{drive: DRIVE_W'(4096), default: '0};
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_PRE_B0:  coef_ff.pre_b0  <= csr_data;
            REG_PRE_A1:  coef_ff.pre_a1  <= csr_data;
            REG_PRE_A2:  coef_ff.pre_a2  <= csr_data;
            REG_POST_B0: coef_ff.post_b0 <= csr_data;
            REG_POST_A1: coef_ff.post_a1 <= csr_data;
            REG_POST_A2: coef_ff.post_a2 <= csr_data;
            REG_DRIVE:   coef_ff.drive   <= csr_data[DRIVE_W-1:0];
            REG_GAIN:    coef_ff.harmonic_gain <= csr_data;
            default: ;   // drop writes beyond the register list
         endcase
      end
   end

   sheu_lane u_lane_left (
      .clock(clock), .reset(reset), .coef(coef_ff), .ctrl(ctrl),
      .sample_in(req_tdata[23:0]), .stat(stat_l), .sample_out(out_l)
   );

   sheu_lane u_lane_right (
      .clock(clock), .reset(reset), .coef(coef_ff), .ctrl(ctrl),
      .sample_in(req_tdata[47:24]), .stat(stat_r), .sample_out(out_r)
   );

   always_ff @(posedge clock) begin
      if (merge) rsp_data_ff <= {out_r, out_l};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) busy_ff <= 1'b1;
         else if (merge) busy_ff <= 1'b0;
         if (merge) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/core/sheu_lane.sv
// ----------------------------------------------------------------------------
// sheu_lane: one channel of the exciter
// Highpass, drive and tanh shaping, highpass, mix; one shared multiplier.
// ----------------------------------------------------------------------------
module sheu_lane
   import sheu_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  coef_type                      coef,
   input  lane_ctrl_type                 ctrl,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   output lane_stat_type                 stat,
   output logic signed [SAMPLE_BITS-1:0] sample_out
);

   localparam tanh_rom_type TANH_ROM = build_tanh_rom();
   localparam int KSH = FRAC + 2 - TANH_LOG2;

   lane_step_type step_ff, step_in;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [SAMPLE_BITS-1:0] pxh1_ff, pxh2_ff, pyh1_ff, pyh2_ff;
   logic signed [SAMPLE_BITS-1:0] qxh1_ff, qxh2_ff, qyh1_ff, qyh2_ff;
   logic signed [ACC_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic                          neg_ff;
   logic [TANH_IDX_W-1:0]         k_ff;
   logic [FRAC-1:0]               tab_ff;
   logic signed [SAMPLE_BITS-1:0] out_ff;
   logic                          done_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_A_W-1:0] d_pre, d_post;
   logic signed [SAMPLE_BITS-1:0] s_val;
   logic signed [ACC_W-1:0]   rnd_acc, u_val, mag, r_val;
   logic signed [ACC_W-1:0]   k_wide;

   assign d_pre  = MUL_A_W'(x_ff) - (MUL_A_W'(pxh1_ff) <<< 1) + MUL_A_W'(pxh2_ff);
   assign s_val  = neg_ff ? -$signed({1'b0, tab_ff}) : $signed({1'b0, tab_ff});
   assign d_post = MUL_A_W'(s_val) - (MUL_A_W'(qxh1_ff) <<< 1) + MUL_A_W'(qxh2_ff);
   assign rnd_acc = (acc_ff + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
   assign u_val   = (prod_ff + (ACC_W'(1) <<< 11)) >>> 12;
   assign r_val   = (prod_ff + (ACC_W'(1) <<< 15)) >>> 16;

   always_comb begin
      mag = u_val[ACC_W-1] ? -u_val : u_val;
      if (mag > (ACC_W'(4) <<< FRAC)) mag = ACC_W'(4) <<< FRAC;
      k_wide = (mag + (ACC_W'(1) <<< (KSH - 1))) >>> KSH;
      if (k_wide > ACC_W'(TANH_TABLE_DEPTH)) k_wide = ACC_W'(TANH_TABLE_DEPTH);
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (step_ff)
         ST_PRE_B0:  begin mul_a = d_pre; mul_b = MUL_B_W'(coef.pre_b0); end
         ST_PRE_A1:  begin mul_a = MUL_A_W'(pyh1_ff); mul_b = MUL_B_W'(coef.pre_a1); end
         ST_PRE_A2:  begin mul_a = MUL_A_W'(pyh2_ff); mul_b = MUL_B_W'(coef.pre_a2); end
         ST_DRIVE:   begin
            mul_a = MUL_A_W'(pyh1_ff);
            mul_b = $signed(MUL_B_W'(coef.drive));
         end
         ST_POST_B0: begin mul_a = d_post; mul_b = MUL_B_W'(coef.post_b0); end
         ST_POST_A1: begin mul_a = MUL_A_W'(qyh1_ff); mul_b = MUL_B_W'(coef.post_a1); end
         ST_POST_A2: begin mul_a = MUL_A_W'(qyh2_ff); mul_b = MUL_B_W'(coef.post_a2); end
         ST_GAIN:    begin
            mul_a = MUL_A_W'(qyh1_ff);
            mul_b = $signed(MUL_B_W'(coef.harmonic_gain));
         end
         default: ;
      endcase
      prod_in = ACC_W'(mul_a) * ACC_W'(mul_b);
   end

   always_comb begin
      step_in = step_ff;
      acc_in  = acc_ff;
      unique case (step_ff)
         ST_PRE_A1, ST_POST_A1:   acc_in = prod_ff;
         ST_PRE_A2, ST_PRE_ACC,
         ST_POST_A2, ST_POST_ACC: acc_in = acc_ff - prod_ff;
         default: ;
      endcase
      if (ctrl.start) step_in = ST_PRE_B0;
      else if (step_ff != ST_IDLE) step_in = lane_step_type'(step_ff + 4'd1);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (ctrl.start) x_ff <= sample_in;
      if (step_ff == ST_INDEX) begin
         neg_ff <= u_val[ACC_W-1];
         k_ff   <= k_wide[TANH_IDX_W-1:0];
      end
      if (step_ff == ST_LOOKUP) tab_ff <= TANH_ROM[k_ff];
      if (step_ff == ST_MIX) out_ff <= sat_sample(64'(x_ff) + 64'(r_val));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
         done_ff <= 1'b0;
         pxh1_ff <= '0; pxh2_ff <= '0; pyh1_ff <= '0; pyh2_ff <= '0;
         qxh1_ff <= '0; qxh2_ff <= '0; qyh1_ff <= '0; qyh2_ff <= '0;
      end else begin
         step_ff <= step_in;
         if (ctrl.start) done_ff <= 1'b0;
         else if (step_ff == ST_MIX) done_ff <= 1'b1;
         if (step_ff == ST_PRE_OUT) begin
            pxh2_ff <= pxh1_ff;
            pxh1_ff <= x_ff;
            pyh2_ff <= pyh1_ff;
            pyh1_ff <= sat_sample(64'(rnd_acc));
         end
         if (step_ff == ST_POST_B0) begin
            qxh2_ff <= qxh1_ff;
            qxh1_ff <= s_val;
         end
         if (step_ff == ST_POST_OUT) begin
            qyh2_ff <= qyh1_ff;
            qyh1_ff <= sat_sample(64'(rnd_acc));
         end
      end
   end

   assign stat.done  = done_ff;
   assign sample_out = out_ff;

endmodule

// File: rtl/core/sheu_checker.sv
// ----------------------------------------------------------------------------
// sheu_checker: port-level checks of the stereo harmonic exciter
// Response hold, request spacing and reset behavior.
// ----------------------------------------------------------------------------
module sheu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // a request keeps the block busy in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // no response appears right after a request
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response too early");

   // reset empties the output
   assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("output not cleared by reset");

endmodule

bind stereo_harmonic_exciter_unit sheu_checker u_sheu_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// File: tb/stereo_harmonic_exciter_unit_tb.sv
// ----------------------------------------------------------------------------
// stereo_harmonic_exciter_unit_tb: self-checking bench of the stereo exciter
// Streams stereo frames through the unit under several register settings,
// predicts each response frame in the bench and compares it field by field.
// ----------------------------------------------------------------------------
module stereo_harmonic_exciter_unit_tb
   import sheu_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 40;
   localparam longint SMAX       = (64'sd1 <<< FRAC) - 1;
   localparam longint SMIN       = -(64'sd1 <<< FRAC);

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [47:0]          req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [47:0]          rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [23:0]          csr_data;

   stereo_harmonic_exciter_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // shadow registers and filter histories, channel*2 + delay
   longint m_pre_b0, m_pre_a1, m_pre_a2, m_post_b0, m_post_a1, m_post_a2;
   longint m_drive, m_gain;
   longint pre_xh[4], pre_yh[4], post_xh[4], post_yh[4];
   longint tanh_lut[TANH_TABLE_DEPTH+1];

   logic [47:0] frame_q[$];     // frames waiting to be sent
   logic [47:0] excited_q[$];   // predicted response frames
   logic        no_idle;
   int          mismatches, frames_sent, frames_checked, cfg_writes, wd_count;

   // tanh(4k/DEPTH) through e^-2x = (e^-z)^16, 32-bit fraction fixed point
   function automatic longint tanh_point(int unsigned k);
      logic [127:0] m64, one, z, term, pos, neg, e, r;
      m64  = {64'd0, {64{1'b1}}};
      one  = 128'd1 << 32;
      z    = (128'(k) << 32) / (2 * TANH_TABLE_DEPTH);
      term = one;
      pos  = one;
      neg  = '0;
      for (int n = 1; n <= 12; n++) begin
         term = ((term * z) >> 32) / n;
         if (n % 2 == 1) neg = neg + term;
         else pos = pos + term;
      end
      e = (pos - neg) & m64;
      if (e > 128'hFFFF_FFFF) e = 128'hFFFF_FFFF;
      for (int i = 0; i < 4; i++) e = (e * e) >> 32;
      r = (((one - e) << 32) & m64) / (one + e);
      r = (r + (128'd1 << (31 - FRAC))) >> (32 - FRAC);
      if (r > (128'd1 << FRAC) - 1) r = (128'd1 << FRAC) - 1;
      return longint'(r[63:0]);
   endfunction

   function automatic longint clip24(longint v);
      return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
   endfunction

   // add half, then floor shift
   function automatic longint round_half_up(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint highpass(longint x, longint b0, longint a1, longint a2,
                                       ref longint xh[4], ref longint yh[4], input int c);
      longint acc, y;
      acc = b0 * (x - 2 * xh[2*c] + xh[2*c+1]) - a1 * yh[2*c] - a2 * yh[2*c+1];
      y = clip24(round_half_up(acc, COEF_FRAC_BITS));
      xh[2*c+1] = xh[2*c]; xh[2*c] = x;
      yh[2*c+1] = yh[2*c]; yh[2*c] = y;
      return y;
   endfunction

   function automatic longint excite_sample(int c, logic signed [23:0] dry);
      longint x, h, u, mag, k, s, g;
      x = longint'(dry);
      h = highpass(x, m_pre_b0, m_pre_a1, m_pre_a2, pre_xh, pre_yh, c);
      u = round_half_up(m_drive * h, 12);
      mag = u < 0 ? -u : u;
      if (mag > (64'sd4 <<< FRAC)) mag = 64'sd4 <<< FRAC;
      k = round_half_up(mag * TANH_TABLE_DEPTH, FRAC + 2);
      if (k > TANH_TABLE_DEPTH) k = TANH_TABLE_DEPTH;
      s = u < 0 ? -tanh_lut[k] : tanh_lut[k];
      g = highpass(s, m_post_b0, m_post_a1, m_post_a2, post_xh, post_yh, c);
      return clip24(x + round_half_up(m_gain * g, 16));
   endfunction

   function automatic logic [47:0] excite_frame(logic [47:0] d);
      longint l, r;
      l = excite_sample(0, d[23:0]);
      r = excite_sample(1, d[47:24]);
      return {r[23:0], l[23:0]};
   endfunction

   // Driver: hold a pending request until taken, predict on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            excited_q.push_back(excite_frame(req_tdata));
            void'(frame_q.pop_front());
            frames_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (frame_q.size() > 0 && (no_idle || $urandom_range(99) >= 33)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= frame_q[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random back-pressure, compare each response with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || $urandom_range(99) >= 33;
         if (rsp_tvalid && rsp_tready) begin
            if (excited_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response %h", rsp_tdata);
            end else begin
               if (rsp_tdata[23:0] !== excited_q[0][23:0] ||
                   rsp_tdata[47:24] !== excited_q[0][47:24]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: left exp %h got %h, right exp %h got %h",
                              excited_q[0][23:0], rsp_tdata[23:0],
                              excited_q[0][47:24], rsp_tdata[47:24]);
               end
               void'(excited_q.pop_front());
               frames_checked++;
            end
         end
      end
   end

   // Watchdog: count cycles with no handshake of any kind.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         wd_count <= 0;
      else
         wd_count <= wd_count + 1;
      if (wd_count >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d responses outstanding", excited_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Leave csr_valid high so back-to-back writes never toggle it in one step.
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      cfg_writes++;
      case (idx)
         REG_PRE_B0:  m_pre_b0  = longint'(signed'(val));
         REG_PRE_A1:  m_pre_a1  = longint'(signed'(val));
         REG_PRE_A2:  m_pre_a2  = longint'(signed'(val));
         REG_POST_B0: m_post_b0 = longint'(signed'(val));
         REG_POST_A1: m_post_a1 = longint'(signed'(val));
         REG_POST_A2: m_post_a2 = longint'(signed'(val));
         REG_DRIVE:   m_drive   = longint'(val[15:0]);
         REG_GAIN:    m_gain    = longint'(val);
         default: ;  // unknown index: drop
      endcase
   endtask

   task automatic load_settings(logic [23:0] pb0, logic [23:0] pa1, logic [23:0] pa2,
                                logic [23:0] qb0, logic [23:0] qa1, logic [23:0] qa2,
                                logic [23:0] drv, logic [23:0] gain);
      csr_write(REG_PRE_B0, pb0);
      csr_write(REG_PRE_A1, pa1);
      csr_write(REG_PRE_A2, pa2);
      csr_write(REG_POST_B0, qb0);
      csr_write(REG_POST_A1, qa1);
      csr_write(REG_POST_A2, qa2);
      csr_write(REG_DRIVE, drv);
      csr_write(REG_GAIN, gain);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait for every prediction to be matched, then let the lanes settle.
   task automatic drain();
      while (frame_q.size() != 0 || excited_q.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_sample();
      case ($urandom_range(9))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2, 3: return 24'($signed($urandom_range(4000)) - 2000);
         default: return 24'($urandom);
      endcase
   endfunction

   // coefficients near a usable highpass, with random spread
   function automatic logic [23:0] near(int centre, int spread);
      return 24'(centre + $signed($urandom_range(2 * spread)) - spread);
   endfunction

   initial begin
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      no_idle    = 1'b0;
      mismatches = 0; frames_sent = 0; frames_checked = 0; cfg_writes = 0;
      for (int k = 0; k <= TANH_TABLE_DEPTH; k++) tanh_lut[k] = tanh_point(k);
      m_pre_b0 = 0; m_pre_a1 = 0; m_pre_a2 = 0;
      m_post_b0 = 0; m_post_a1 = 0; m_post_a2 = 0;
      m_drive = 4096; m_gain = 0;
      for (int i = 0; i < 4; i++) begin
         pre_xh[i] = 0; pre_yh[i] = 0; post_xh[i] = 0; post_yh[i] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero gain, the response is the dry frame
      frame_q = '{48'h000000_000000, 48'h800000_7FFFFF, 48'h7FFFFF_800000,
                  48'h7FFFFF_7FFFFF, 48'h800000_800000, 48'hFFFFFF_000001};
      drain();

      // extreme coefficients, full drive and gain: filter and output overflow,
      // shaper clamp; unknown indexes must be ignored
      load_settings(24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                    24'h7FFFFF, 24'h800000, 24'h800000, 24'h00FFFF, 24'hFFFFFF);
      csr_write(8'd8, 24'h123456);
      csr_write(8'd255, 24'hFFFFFF);
      csr_valid <= 1'b0;
      frame_q = '{48'h800000_7FFFFF, 48'h7FFFFF_800000, 48'h800000_7FFFFF,
                  48'h000000_000000, 48'h7FFFFF_7FFFFF, 48'h800000_800000,
                  48'h000001_FFFFFF, 48'h555555_AAAAAA};
      drain();

      // drive zero gives no harmonics, then the minimum usable drive
      load_settings(24'd3774873, -24'sd6710886, 24'd2684355,
                    24'd3774873, -24'sd6710886, 24'd2684355, 24'd0, 24'd65536);
      frame_q = '{48'h7FFFFF_800000, 48'h800000_7FFFFF, 48'h000000_000000};
      drain();
      load_settings(24'd3774873, -24'sd6710886, 24'd2684355,
                    24'd3774873, -24'sd6710886, 24'd2684355, 24'd41, 24'hFFFFFF);
      frame_q = '{48'h7FFFFF_800000, 48'h800000_7FFFFF, 48'h123456_654321};
      drain();

      // random phases: mostly stable highpass settings, some fully random
      for (int ph = 0; ph < 8; ph++) begin
         if (ph % 3 == 2)
            load_settings(24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom), 24'($urandom));
         else
            load_settings(near(3774873, 300000), near(-6710886, 300000),
                          near(2684355, 200000), near(3774873, 300000),
                          near(-6710886, 300000), near(2684355, 200000),
                          24'($urandom_range(65535, 41)), 24'($urandom_range(500000)));
         no_idle = (ph == 4);
         for (int n = 0; n < 125; n++)
            frame_q.push_back({rand_sample(), rand_sample()});
         drain();
      end
      no_idle = 1'b0;

      $display("sent %0d frames, checked %0d responses, %0d register writes",
               frames_sent, frames_checked, cfg_writes);
      $display("settings covered: reset, extremes, zero and minimum drive, random");
      if (mismatches == 0 && excited_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/sheu_pkg.sv
rtl/core/sheu_lane.sv
rtl/core/stereo_harmonic_exciter_unit.sv
rtl/core/sheu_checker.sv
tb/stereo_harmonic_exciter_unit_tb.sv
